>>> hw/rtl/dpc_pkg.sv
package dpc_pkg;

  // default widths
  localparam int COORD_BITS_DEF = 12;
  localparam int DEPTH_BITS_DEF = 24;

  // fixed field widths
  localparam int INTR_W  = 16;
  localparam int DISP_W  = 16;
  localparam int COLOR_W = 24;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_USE_COLOR = 3'd5;

  // register reset values
  localparam logic [INTR_W-1:0] RST_FOCAL_X  = 16'd8000;
  localparam logic [INTR_W-1:0] RST_FOCAL_Y  = 16'd8000;
  localparam logic [INTR_W-1:0] RST_CENTER_X = 16'd5120;
  localparam logic [INTR_W-1:0] RST_CENTER_Y = 16'd3840;
  localparam logic [INTR_W-1:0] RST_BASELINE = 16'd120;

endpackage

>>> hw/rtl/dpc_div.sv
// Pipelined restoring divider: one quotient bit per stage, a new beat every cycle.
// Divisor zero gives all ones; the caller handles that case.
module dpc_div #(
  parameter int NUM_W  = 34,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld  [0:NUM_W];
  logic [NUM_W-1:0]  num  [0:NUM_W];
  logic [NUM_W-1:0]  quo  [0:NUM_W];
  logic [DEN_W-1:0]  rem  [0:NUM_W];
  logic [DEN_W-1:0]  den  [0:NUM_W];
  logic [SIDE_W-1:0] side [0:NUM_W];

  // stage 0 is the incoming beat
  assign vld[0]  = in_valid;
  assign num[0]  = in_num;
  assign quo[0]  = '0;
  assign rem[0]  = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0]    trial;
    logic              take;
    logic              vld_q;
    logic [NUM_W-1:0]  num_q;
    logic [NUM_W-1:0]  quo_q;
    logic [DEN_W-1:0]  rem_q;
    logic [DEN_W-1:0]  den_q;
    logic [SIDE_W-1:0] side_q;

    // shift in the next numerator bit and try the subtract
    assign trial = {rem[s], num[s][NUM_W-1]};
    assign take  = (trial >= {1'b0, den[s]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      num_q  <= {num[s][NUM_W-2:0], 1'b0};
      quo_q  <= {quo[s][NUM_W-2:0], take};
      rem_q  <= take ? DEN_W'(trial - {1'b0, den[s]}) : trial[DEN_W-1:0];
      den_q  <= den[s];
      side_q <= side[s];
    end

    assign vld[s+1]  = vld_q;
    assign num[s+1]  = num_q;
    assign quo[s+1]  = quo_q;
    assign rem[s+1]  = rem_q;
    assign den[s+1]  = den_q;
    assign side[s+1] = side_q;
  end

  assign out_valid = vld[NUM_W];
  assign out_quo   = quo[NUM_W];
  assign out_side  = side[NUM_W];

endmodule

>>> hw/rtl/disparity_to_point_cloud.sv
// Channel   | Handshake                 | Payload
// ----------+---------------------------+-------------------------------------------
// pixel in  | start & !busy             | column, row, disparity, red, green, blue
// point out | done strobe, one cycle    | point_x, point_y, point_z, packed_color
// config    | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
// One beat enters every cycle; busy is never raised.
// The stages run: capture, focal times baseline, depth divider, saturate and offset,
// offset times depth, x/y dividers, output register; each divider makes one quotient bit per stage.
// Reset (rst, synchronous) empties the pipeline and restores the registers.
// The receiver cannot stall: each result shows on done for exactly one cycle.
module disparity_to_point_cloud #(
  parameter int COORD_BITS = dpc_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = dpc_pkg::DEPTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [COORD_BITS-1:0]           column,
  input  logic [COORD_BITS-1:0]           row,
  input  logic [dpc_pkg::DISP_W-1:0]      disparity,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  output logic                            done,
  output logic signed [DEPTH_BITS:0]      point_x,
  output logic signed [DEPTH_BITS:0]      point_y,
  output logic [DEPTH_BITS-1:0]           point_z,
  output logic [dpc_pkg::COLOR_W-1:0]     packed_color,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpc_pkg::INTR_W-1:0]      cfg_data
);

  import dpc_pkg::*;

  localparam int PROD_W = 2 * INTR_W;
  localparam int NZ_W   = PROD_W + 2;
  localparam int P16_W  = COORD_BITS + 4;
  localparam int MAG_W  = (P16_W > INTR_W) ? P16_W : INTR_W;
  localparam int PW     = MAG_W + DEPTH_BITS;
  localparam int ZSIDE_W = 2 * COORD_BITS + COLOR_W + 1;
  localparam int XSIDE_W = DEPTH_BITS + COLOR_W + 1;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  // configuration registers
  logic [INTR_W-1:0] focal_x, focal_y, center_x, center_y, baseline_mm;
  logic              use_color;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x     <= RST_FOCAL_X;
      focal_y     <= RST_FOCAL_Y;
      center_x    <= RST_CENTER_X;
      center_y    <= RST_CENTER_Y;
      baseline_mm <= RST_BASELINE;
      use_color   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FOCAL_X:   focal_x     <= cfg_data;
        REG_FOCAL_Y:   focal_y     <= cfg_data;
        REG_CENTER_X:  center_x    <= cfg_data;
        REG_CENTER_Y:  center_y    <= cfg_data;
        REG_BASELINE:  baseline_mm <= cfg_data;
        REG_USE_COLOR: use_color   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage 1: capture the pixel, pack colour (zero when use_color is clear)
  logic                  s1_vld;
  logic [COORD_BITS-1:0] s1_col, s1_row;
  logic [DISP_W-1:0]     s1_disp;
  logic [COLOR_W-1:0]    s1_color;

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_col   <= column;
    s1_row   <= row;
    s1_disp  <= disparity;
    s1_color <= use_color ? {red, green, blue} : '0;
  end

  // stage 2: focal_x times baseline
  logic                  s2_vld;
  logic [COORD_BITS-1:0] s2_col, s2_row;
  logic [DISP_W-1:0]     s2_disp;
  logic [COLOR_W-1:0]    s2_color;
  logic [PROD_W-1:0]     s2_fb;

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else     s2_vld <= s1_vld;
  end

  always_ff @(posedge clk) begin
    s2_col   <= s1_col;
    s2_row   <= s1_row;
    s2_disp  <= s1_disp;
    s2_color <= s1_color;
    s2_fb    <= focal_x * baseline_mm;
  end

  // depth divider
  logic              zd_vld;
  logic [NZ_W-1:0]   zd_quo;
  logic [ZSIDE_W-1:0] zd_side;

  dpc_div #(.NUM_W(NZ_W), .DEN_W(DISP_W), .SIDE_W(ZSIDE_W)) u_div_z (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_vld),
    .in_num   ({s2_fb, 2'b00}),
    .in_den   (s2_disp),
    .in_side  ({s2_col, s2_row, s2_color, (s2_disp == '0)}),
    .out_valid(zd_vld),
    .out_quo  (zd_quo),
    .out_side (zd_side)
  );

  logic [COORD_BITS-1:0] zd_col, zd_row;
  logic [COLOR_W-1:0]    zd_color;
  logic                  zd_dzero;
  assign {zd_col, zd_row, zd_color, zd_dzero} = zd_side;

  // stage A: saturate depth (zero for zero disparity), offsets from the principal point
  logic [P16_W-1:0]      p16x, p16y;
  assign p16x = {zd_col, 4'b0000};
  assign p16y = {zd_row, 4'b0000};

  logic                  sa_vld;
  logic [DEPTH_BITS-1:0] sa_z;
  logic [MAG_W-1:0]      sa_magx, sa_magy;
  logic                  sa_negx, sa_negy;
  logic [COLOR_W-1:0]    sa_color;

  always_ff @(posedge clk) begin
    if (rst) sa_vld <= 1'b0;
    else     sa_vld <= zd_vld;
  end

  always_ff @(posedge clk) begin
    if (zd_dzero)                                  sa_z <= '0;
    else if (zd_quo > NZ_W'(DEPTH_MAX))            sa_z <= DEPTH_MAX;
    else                                           sa_z <= zd_quo[DEPTH_BITS-1:0];
    sa_negx  <= MAG_W'(p16x) < MAG_W'(center_x);
    sa_negy  <= MAG_W'(p16y) < MAG_W'(center_y);
    sa_magx  <= (MAG_W'(p16x) < MAG_W'(center_x)) ? MAG_W'(center_x) - MAG_W'(p16x)
                                                  : MAG_W'(p16x) - MAG_W'(center_x);
    sa_magy  <= (MAG_W'(p16y) < MAG_W'(center_y)) ? MAG_W'(center_y) - MAG_W'(p16y)
                                                  : MAG_W'(p16y) - MAG_W'(center_y);
    sa_color <= zd_color;
  end

  // stage B: offset times depth
  logic                  sb_vld;
  logic [PW-1:0]         sb_px, sb_py;
  logic [DEPTH_BITS-1:0] sb_z;
  logic                  sb_negx, sb_negy;
  logic [COLOR_W-1:0]    sb_color;

  always_ff @(posedge clk) begin
    if (rst) sb_vld <= 1'b0;
    else     sb_vld <= sa_vld;
  end

  always_ff @(posedge clk) begin
    sb_px    <= PW'(sa_magx) * PW'(sa_z);
    sb_py    <= PW'(sa_magy) * PW'(sa_z);
    sb_z     <= sa_z;
    sb_negx  <= sa_negx;
    sb_negy  <= sa_negy;
    sb_color <= sa_color;
  end

  // x and y dividers run side by side
  logic               xd_vld, yd_vld;
  logic [PW-1:0]      xd_quo, yd_quo;
  logic [XSIDE_W-1:0] xd_side;
  logic               yd_negy;

  dpc_div #(.NUM_W(PW), .DEN_W(INTR_W), .SIDE_W(XSIDE_W)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sb_vld),
    .in_num   (sb_px),
    .in_den   (focal_x),
    .in_side  ({sb_z, sb_color, sb_negx}),
    .out_valid(xd_vld),
    .out_quo  (xd_quo),
    .out_side (xd_side)
  );

  dpc_div #(.NUM_W(PW), .DEN_W(INTR_W), .SIDE_W(1)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sb_vld),
    .in_num   (sb_py),
    .in_den   (focal_y),
    .in_side  (sb_negy),
    .out_valid(yd_vld),
    .out_quo  (yd_quo),
    .out_side (yd_negy)
  );

  logic [DEPTH_BITS-1:0] xd_z;
  logic [COLOR_W-1:0]    xd_color;
  logic                  xd_negx;
  assign {xd_z, xd_color, xd_negx} = xd_side;

  // saturate, zero focal gives zero, restore sign
  logic [DEPTH_BITS-1:0] qx_sat, qy_sat;
  always_comb begin
    if (focal_x == '0)                 qx_sat = '0;
    else if (xd_quo > PW'(DEPTH_MAX))  qx_sat = DEPTH_MAX;
    else                               qx_sat = xd_quo[DEPTH_BITS-1:0];
    if (focal_y == '0)                 qy_sat = '0;
    else if (yd_quo > PW'(DEPTH_MAX))  qy_sat = DEPTH_MAX;
    else                               qy_sat = yd_quo[DEPTH_BITS-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= xd_vld && yd_vld;
  end

  always_ff @(posedge clk) begin
    point_x      <= xd_negx ? -$signed({1'b0, qx_sat}) : $signed({1'b0, qx_sat});
    point_y      <= yd_negy ? -$signed({1'b0, qy_sat}) : $signed({1'b0, qy_sat});
    point_z      <= xd_z;
    packed_color <= xd_color;
  end

  // checks
  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    done && point_z == '0 |-> point_x == '0 && point_y == '0)
    else $error("nonzero point for zero depth");

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    done |-> point_x != {1'b1, {DEPTH_BITS{1'b0}}} && point_y != {1'b1, {DEPTH_BITS{1'b0}}})
    else $error("coordinate beyond saturation");

  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result straight after reset");

endmodule
